// ===== design/fcvm_pkg.sv =====
// ----------------------------------------------------------------------------
// fcvm_pkg
// Shared constants, the arctangent table and the controller command type for
// the fly camera view matrix block.
// ----------------------------------------------------------------------------
package fcvm_pkg;

	// Angles are held in 1/64 degree.
	localparam int YAW_FULL          = 23040;
	localparam int YAW_HALF          = 11520;
	localparam int YAW_QUARTER       = 5760;
	localparam int YAW_THREE_QUARTER = 17280;
	localparam int PITCH_LIMIT       = 5696;
	localparam int YAW_RESET         = 5760;
	localparam int PITCH_RESET       = -1920;

	localparam int CORDIC_STEPS = 16;
	localparam int CORDIC_FRAC  = 30;
	localparam int POS_FRAC     = 16;
	localparam int CX_W         = 34;
	localparam int CZ_W         = 26;
	localparam int ITER_W       = 4;

	localparam logic signed [CX_W-1:0] CORDIC_X0 = 34'sd652032874;

	localparam logic CMD_STEP  = 1'b0;
	localparam logic CMD_PLACE = 1'b1;

	localparam logic [2:0] DIR_FWD   = 3'd1;
	localparam logic [2:0] DIR_BACK  = 3'd2;
	localparam logic [2:0] DIR_LEFT  = 3'd3;
	localparam logic [2:0] DIR_RIGHT = 3'd4;
	localparam logic [2:0] DIR_UP    = 3'd5;
	localparam logic [2:0] DIR_DOWN  = 3'd6;

	localparam logic [1:0] ROW_RIGHT = 2'd0;
	localparam logic [1:0] ROW_UP    = 2'd1;
	localparam logic [1:0] ROW_FRONT = 2'd2;

	// Arctangent of 2^-i in 2^-16 degree.
	function automatic logic signed [CZ_W-1:0] atan_step(input logic [ITER_W-1:0] i);
		logic signed [CZ_W-1:0] a;
		case (i)
			4'd0:    a = 26'sd2949120;
			4'd1:    a = 26'sd1740967;
			4'd2:    a = 26'sd919879;
			4'd3:    a = 26'sd466945;
			4'd4:    a = 26'sd234379;
			4'd5:    a = 26'sd117304;
			4'd6:    a = 26'sd58666;
			4'd7:    a = 26'sd29335;
			4'd8:    a = 26'sd14668;
			4'd9:    a = 26'sd7334;
			4'd10:   a = 26'sd3667;
			4'd11:   a = 26'sd1833;
			4'd12:   a = 26'sd917;
			4'd13:   a = 26'sd458;
			4'd14:   a = 26'sd229;
			4'd15:   a = 26'sd115;
			default: a = '0;
		endcase
		return a;
	endfunction

	typedef struct packed {
		logic              load;
		logic              cord_init;
		logic              cord_pitch;
		logic              cord_iter;
		logic              cord_wr;
		logic [ITER_W-1:0] iter;
		logic              mul_go;
		logic [1:0]        mul_idx;
		logic              move;
		logic              dot_go;
		logic [2:0]        term;
		logic [1:0]        row;
		logic              out_load;
	} fcvm_cmd_t;

endpackage

// ===== design/fcvm_in_if.sv =====
// ----------------------------------------------------------------------------
// fcvm_in_if
// Input channel: one camera command per beat.
// ----------------------------------------------------------------------------
interface fcvm_in_if;
	logic               valid;
	logic               ready;
	logic               cmd;
	logic signed [14:0] delta_yaw;
	logic signed [14:0] delta_pitch;
	logic [2:0]         move_direction;
	logic signed [31:0] place_x;
	logic signed [31:0] place_y;
	logic signed [31:0] place_z;

	modport source (output valid, cmd, delta_yaw, delta_pitch, move_direction,
		place_x, place_y, place_z, input ready);
	modport sink (input valid, cmd, delta_yaw, delta_pitch, move_direction,
		place_x, place_y, place_z, output ready);
endinterface

// ===== design/fcvm_out_if.sv =====
// ----------------------------------------------------------------------------
// fcvm_out_if
// Output channel: one view matrix row per beat.
// ----------------------------------------------------------------------------
interface fcvm_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         row_index;
	logic signed [15:0] axis_x;
	logic signed [15:0] axis_y;
	logic signed [15:0] axis_z;
	logic signed [31:0] offset;
	logic               last;

	modport source (output valid, row_index, axis_x, axis_y, axis_z, offset, last,
		input ready);
	modport sink (input valid, row_index, axis_x, axis_y, axis_z, offset, last,
		output ready);
endinterface

// ===== design/fcvm_ctrl.sv =====
// ----------------------------------------------------------------------------
// fcvm_ctrl
// Sequencer: loads a command, runs the yaw and pitch rotations, the axis
// products, the move and the three row dot products, then hands out rows.
// ----------------------------------------------------------------------------
module fcvm_ctrl import fcvm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output fcvm_cmd_t ctl
);

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_YINIT = 12'b000000000010,
		S_YAW   = 12'b000000000100,
		S_YWR   = 12'b000000001000,
		S_PINIT = 12'b000000010000,
		S_PIT   = 12'b000000100000,
		S_PWR   = 12'b000001000000,
		S_FMUL  = 12'b000010000000,
		S_MOVE  = 12'b000100000000,
		S_DOT   = 12'b001000000000,
		S_OLOAD = 12'b010000000000,
		S_OUT   = 12'b100000000000
	} state_t;

	localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CORDIC_STEPS - 1);
	localparam logic [ITER_W-1:0] FMUL_END  = 4'd4;
	localparam logic [ITER_W-1:0] DOT_END   = 4'd6;

	state_t            state_q, state_d;
	logic [ITER_W-1:0] cnt_q, cnt_d;
	logic [1:0]        row_q, row_d;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		row_d   = row_q;
		ctl     = '0;
		ctl.iter    = cnt_q;
		ctl.mul_idx = cnt_q[1:0];
		ctl.term    = cnt_q[2:0];
		ctl.row     = row_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = S_YINIT;
				end
			end
			S_YINIT: begin
				ctl.cord_init = 1'b1;
				cnt_d   = '0;
				state_d = S_YAW;
			end
			S_YAW: begin
				ctl.cord_iter = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == LAST_ITER) state_d = S_YWR;
			end
			S_YWR: begin
				ctl.cord_wr = 1'b1;
				state_d = S_PINIT;
			end
			S_PINIT: begin
				ctl.cord_init  = 1'b1;
				ctl.cord_pitch = 1'b1;
				cnt_d   = '0;
				state_d = S_PIT;
			end
			S_PIT: begin
				ctl.cord_iter  = 1'b1;
				ctl.cord_pitch = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == LAST_ITER) state_d = S_PWR;
			end
			S_PWR: begin
				ctl.cord_wr    = 1'b1;
				ctl.cord_pitch = 1'b1;
				cnt_d   = '0;
				state_d = S_FMUL;
			end
			S_FMUL: begin
				// The last product lands in the cycle after it is issued.
				ctl.mul_go = (cnt_q != FMUL_END);
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == FMUL_END) state_d = S_MOVE;
			end
			S_MOVE: begin
				ctl.move = 1'b1;
				cnt_d   = '0;
				row_d   = ROW_RIGHT;
				state_d = S_DOT;
			end
			S_DOT: begin
				ctl.dot_go = (cnt_q != DOT_END);
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == DOT_END) state_d = S_OLOAD;
			end
			S_OLOAD: begin
				ctl.out_load = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_ready) begin
					cnt_d = '0;
					if (row_q == ROW_FRONT) begin
						state_d = S_IDLE;
					end else begin
						row_d   = row_q + 1'b1;
						state_d = S_DOT;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			row_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			row_q   <= row_d;
		end
	end

endmodule

// ===== design/fcvm_datapath.sv =====
// ----------------------------------------------------------------------------
// fcvm_datapath
// Camera state, a shared CORDIC rotator, one shared multiplier with its
// accumulator, position update and the output row register.
// ----------------------------------------------------------------------------
module fcvm_datapath import fcvm_pkg::*; #(
	parameter int POS_WIDTH     = 32,
	parameter int VEC_FRAC_BITS = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fcvm_cmd_t          ctl,
	input  logic               cmd,
	input  logic signed [14:0] delta_yaw,
	input  logic signed [14:0] delta_pitch,
	input  logic [2:0]         move_direction,
	input  logic signed [31:0] place_x,
	input  logic signed [31:0] place_y,
	input  logic signed [31:0] place_z,
	output logic [1:0]         row_index,
	output logic signed [15:0] axis_x,
	output logic signed [15:0] axis_y,
	output logic signed [15:0] axis_z,
	output logic signed [31:0] offset,
	output logic               last
);

	localparam int VW     = VEC_FRAC_BITS + 2;
	localparam int PH_W   = POS_WIDTH - POS_FRAC + 1;
	localparam int MB_W0  = (PH_W > POS_FRAC + 1) ? PH_W : POS_FRAC + 1;
	localparam int MB_W   = (MB_W0 > VW) ? MB_W0 : VW;
	localparam int P_W    = VW + MB_W;
	localparam int ACC_W  = P_W + 18;
	localparam int SH     = CORDIC_FRAC - VEC_FRAC_BITS;
	localparam int UP_SH  = (VEC_FRAC_BITS <= POS_FRAC) ? POS_FRAC - VEC_FRAC_BITS : 0;
	localparam int DN_SH  = (VEC_FRAC_BITS > POS_FRAC) ? VEC_FRAC_BITS - POS_FRAC : 0;

	localparam logic signed [ACC_W-1:0] POS_HI =
		{{(ACC_W-POS_WIDTH+1){1'b0}}, {(POS_WIDTH-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] POS_LO = ~POS_HI;
	localparam logic signed [CX_W-1:0]  CRND   = CX_W'(1) << (SH - 1);
	localparam logic signed [CX_W-1:0]  ONE_C  = CX_W'(1) << VEC_FRAC_BITS;
	localparam logic signed [P_W-1:0]   FRND   = P_W'(1) << (VEC_FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] ARND   = ACC_W'(1) << (VEC_FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] MRND   = (ACC_W'(1) << DN_SH) >> 1;

	function automatic logic signed [POS_WIDTH-1:0] sat_pos(input logic signed [ACC_W-1:0] v);
		logic signed [POS_WIDTH-1:0] r;
		if (v > POS_HI)      r = POS_WIDTH'(POS_HI);
		else if (v < POS_LO) r = POS_WIDTH'(POS_LO);
		else                 r = POS_WIDTH'(v);
		return r;
	endfunction

	function automatic logic signed [VW-1:0] round_clamp(input logic signed [CX_W-1:0] v);
		logic signed [CX_W-1:0] r;
		logic signed [VW-1:0]   o;
		r = (v + CRND) >>> SH;
		if (r > ONE_C)       o = VW'(ONE_C);
		else if (r < -ONE_C) o = VW'(-ONE_C);
		else                 o = VW'(r);
		return o;
	endfunction

	// Camera state.
	logic [14:0]                 yaw_q;
	logic signed [13:0]          pitch_q;
	logic signed [POS_WIDTH-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic [2:0]                  dir_q;

	// Rotator.
	logic signed [CX_W-1:0] cx_q, cy_q;
	logic signed [CZ_W-1:0] cz_q;
	logic                   neg_q;

	// Trigonometry and axis products, VEC_FRAC_BITS fraction bits.
	logic signed [VW-1:0] cos_y_q, sin_y_q, cos_p_q, sin_p_q;
	logic signed [VW-1:0] t0_q, t1_q, t2_q, t3_q;

	// Multiplier and accumulator.
	logic signed [P_W-1:0]   prod_q;
	logic                    fm_s1, dot_s1;
	logic [1:0]              idx_s1;
	logic [2:0]              term_s1;
	logic signed [ACC_W-1:0] acc_q;

	// Angle update for a step command.
	logic signed [16:0] ysum, yaw_nx;
	logic signed [15:0] psum, pitch_nx;

	always_comb begin
		ysum = $signed({2'b00, yaw_q}) + 17'(delta_yaw);
		if (ysum < 0)                yaw_nx = ysum + 17'(YAW_FULL);
		else if (ysum >= YAW_FULL)   yaw_nx = ysum - 17'(YAW_FULL);
		else                         yaw_nx = ysum;
		psum = 16'(pitch_q) + 16'(delta_pitch);
		if (psum > PITCH_LIMIT)       pitch_nx = 16'(PITCH_LIMIT);
		else if (psum < -PITCH_LIMIT) pitch_nx = -16'(PITCH_LIMIT);
		else                          pitch_nx = psum;
	end

	// Yaw is folded into plus or minus 90 degrees; the far half negates the result.
	logic signed [15:0] ya, ang_y, ang;
	logic               neg_y;

	always_comb begin
		ya    = $signed({1'b0, yaw_q});
		ang_y = ya;
		neg_y = 1'b0;
		if (ya > YAW_QUARTER && ya <= YAW_THREE_QUARTER) begin
			ang_y = ya - 16'(YAW_HALF);
			neg_y = 1'b1;
		end else if (ya > YAW_THREE_QUARTER) begin
			ang_y = ya - 16'(YAW_FULL);
		end
		ang = ctl.cord_pitch ? 16'(pitch_q) : ang_y;
	end

	logic signed [CX_W-1:0] sx, sy;
	logic signed [VW-1:0]   rc, rs;

	assign sx = cx_q >>> ctl.iter;
	assign sy = cy_q >>> ctl.iter;
	assign rc = round_clamp(cx_q);
	assign rs = round_clamp(cy_q);

	always_ff @(posedge clk) begin
		if (ctl.cord_init) begin
			cx_q  <= CORDIC_X0;
			cy_q  <= '0;
			cz_q  <= CZ_W'(ang) <<< 10;
			neg_q <= neg_y & ~ctl.cord_pitch;
		end else if (ctl.cord_iter) begin
			if (!cz_q[CZ_W-1]) begin
				cx_q <= cx_q - sy;
				cy_q <= cy_q + sx;
				cz_q <= cz_q - atan_step(ctl.iter);
			end else begin
				cx_q <= cx_q + sy;
				cy_q <= cy_q - sx;
				cz_q <= cz_q + atan_step(ctl.iter);
			end
		end
		if (ctl.cord_wr) begin
			if (ctl.cord_pitch) begin
				cos_p_q <= rc;
				sin_p_q <= rs;
			end else begin
				cos_y_q <= neg_q ? -rc : rc;
				sin_y_q <= neg_q ? -rs : rs;
			end
		end
	end

	// Rows: right (-sy, 0, cy), up (-cy*sp, cp, -sy*sp), negated front
	// (-cy*cp, -sp, -sy*cp). The t registers already hold the negated products.
	function automatic logic [3*VW-1:0] row_vec(input logic [1:0] r);
		logic [3*VW-1:0] v;
		case (r)
			ROW_RIGHT: v = {-sin_y_q, VW'(0), cos_y_q};
			ROW_UP:    v = {t0_q, cos_p_q, t1_q};
			ROW_FRONT: v = {t2_q, -sin_p_q, t3_q};
			default:   v = '0;
		endcase
		return v;
	endfunction

	logic [3*VW-1:0] sel_v, mv_v;
	logic            mv_en, mv_neg;

	always_comb begin
		sel_v  = row_vec(ctl.row);
		mv_en  = 1'b1;
		mv_neg = 1'b0;
		case (dir_q)
			DIR_FWD:   begin mv_v = row_vec(ROW_FRONT); mv_neg = 1'b1; end
			DIR_BACK:  mv_v = row_vec(ROW_FRONT);
			DIR_LEFT:  begin mv_v = row_vec(ROW_RIGHT); mv_neg = 1'b1; end
			DIR_RIGHT: mv_v = row_vec(ROW_RIGHT);
			DIR_UP:    mv_v = row_vec(ROW_UP);
			DIR_DOWN:  begin mv_v = row_vec(ROW_UP); mv_neg = 1'b1; end
			default: begin
				mv_v  = '0;
				mv_en = 1'b0;
			end
		endcase
	end

	// One unit of motion in position fraction bits.
	logic signed [ACC_W-1:0] ux, uy, uz;

	assign ux = ((ACC_W'($signed(mv_v[3*VW-1:2*VW])) <<< UP_SH) + MRND) >>> DN_SH;
	assign uy = ((ACC_W'($signed(mv_v[2*VW-1:VW])) <<< UP_SH) + MRND) >>> DN_SH;
	assign uz = ((ACC_W'($signed(mv_v[VW-1:0])) <<< UP_SH) + MRND) >>> DN_SH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_q   <= 15'(YAW_RESET);
			pitch_q <= 14'(PITCH_RESET);
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
			dir_q   <= '0;
		end else if (ctl.load) begin
			if (cmd == CMD_PLACE) begin
				pos_x_q <= sat_pos(ACC_W'(place_x));
				pos_y_q <= sat_pos(ACC_W'(place_y));
				pos_z_q <= sat_pos(ACC_W'(place_z));
				yaw_q   <= 15'(YAW_RESET);
				pitch_q <= 14'(PITCH_RESET);
				dir_q   <= '0;
			end else begin
				yaw_q   <= 15'(yaw_nx);
				pitch_q <= 14'(pitch_nx);
				dir_q   <= move_direction;
			end
		end else if (ctl.move && mv_en) begin
			pos_x_q <= sat_pos(mv_neg ? ACC_W'(pos_x_q) - ux : ACC_W'(pos_x_q) + ux);
			pos_y_q <= sat_pos(mv_neg ? ACC_W'(pos_y_q) - uy : ACC_W'(pos_y_q) + uy);
			pos_z_q <= sat_pos(mv_neg ? ACC_W'(pos_z_q) - uz : ACC_W'(pos_z_q) + uz);
		end
	end

	// Dot products split each position into a signed high part and an unsigned
	// 16-bit low part so that every product fits the one multiplier.
	logic signed [POS_WIDTH-1:0] pos_k;
	logic signed [POS_WIDTH:0]   pos_ext;
	logic signed [VW-1:0]        mul_a;
	logic signed [MB_W-1:0]      mul_b;

	always_comb begin
		case (ctl.term[2:1])
			2'd0:    pos_k = pos_x_q;
			2'd1:    pos_k = pos_y_q;
			default: pos_k = pos_z_q;
		endcase
		pos_ext = (POS_WIDTH+1)'(pos_k);
		if (ctl.mul_go) begin
			mul_a = ctl.mul_idx[0] ? sin_y_q : cos_y_q;
			mul_b = MB_W'(ctl.mul_idx[1] ? cos_p_q : sin_p_q);
		end else begin
			case (ctl.term[2:1])
				2'd0:    mul_a = $signed(sel_v[3*VW-1:2*VW]);
				2'd1:    mul_a = $signed(sel_v[2*VW-1:VW]);
				default: mul_a = $signed(sel_v[VW-1:0]);
			endcase
			if (ctl.term[0])
				mul_b = MB_W'($signed({1'b0, pos_k[POS_FRAC-1:0]}));
			else
				mul_b = MB_W'($signed(pos_ext[POS_WIDTH:POS_FRAC]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fm_s1  <= 1'b0;
			dot_s1 <= 1'b0;
		end else begin
			fm_s1  <= ctl.mul_go;
			dot_s1 <= ctl.dot_go;
		end
	end

	logic signed [P_W-1:0]   fr;
	logic signed [ACC_W-1:0] term_ext, oq;
	logic signed [POS_WIDTH-1:0] off;

	assign fr       = (prod_q + FRND) >>> VEC_FRAC_BITS;
	assign term_ext = term_s1[0] ? ACC_W'(prod_q) : ACC_W'(prod_q) <<< POS_FRAC;
	assign oq       = (acc_q + ARND) >>> VEC_FRAC_BITS;
	assign off      = sat_pos(-oq);

	always_ff @(posedge clk) begin
		prod_q  <= mul_a * mul_b;
		idx_s1  <= ctl.mul_idx;
		term_s1 <= ctl.term;
		if (fm_s1) begin
			case (idx_s1)
				2'd0:    t0_q <= -VW'(fr);
				2'd1:    t1_q <= -VW'(fr);
				2'd2:    t2_q <= -VW'(fr);
				default: t3_q <= -VW'(fr);
			endcase
		end
		if (dot_s1) begin
			acc_q <= (term_s1 == 3'd0) ? term_ext : acc_q + term_ext;
		end
		if (ctl.out_load) begin
			row_index <= ctl.row;
			axis_x    <= 16'($signed(sel_v[3*VW-1:2*VW]));
			axis_y    <= 16'($signed(sel_v[2*VW-1:VW]));
			axis_z    <= 16'($signed(sel_v[VW-1:0]));
			offset    <= 32'(off);
			last      <= (ctl.row == ROW_FRONT);
		end
	end

endmodule

// ===== design/fly_camera_view_matrix.sv =====
// ----------------------------------------------------------------------------
// fly_camera_view_matrix
// First-person camera with yaw, pitch and position that emits its view matrix.
// ----------------------------------------------------------------------------
// Each accepted command produces three row beats (right, up, negated front).
// A command first runs the two 16-iteration CORDIC passes on the one shared
// rotator, the four axis products and the move; each row then takes six
// passes through the single shared multiplier, rounding and the row beat.
// A new command is accepted only after the third row has been taken.
// ----------------------------------------------------------------------------
module fly_camera_view_matrix import fcvm_pkg::*; #(
	parameter int POS_WIDTH     = 32,
	parameter int VEC_FRAC_BITS = 14
) (
	input logic        clk,
	input logic        arst_n,
	fcvm_in_if.sink    step_in,
	fcvm_out_if.source row_out
);

	fcvm_cmd_t ctl;

	fcvm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (step_in.valid),
		.in_ready  (step_in.ready),
		.out_valid (row_out.valid),
		.out_ready (row_out.ready),
		.ctl       (ctl)
	);

	fcvm_datapath #(
		.POS_WIDTH     (POS_WIDTH),
		.VEC_FRAC_BITS (VEC_FRAC_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.cmd            (step_in.cmd),
		.delta_yaw      (step_in.delta_yaw),
		.delta_pitch    (step_in.delta_pitch),
		.move_direction (step_in.move_direction),
		.place_x        (step_in.place_x),
		.place_y        (step_in.place_y),
		.place_z        (step_in.place_z),
		.row_index      (row_out.row_index),
		.axis_x         (row_out.axis_x),
		.axis_y         (row_out.axis_y),
		.axis_z         (row_out.axis_z),
		.offset         (row_out.offset),
		.last           (row_out.last)
	);

endmodule

// ===== design/fcvm_checker.sv =====
// ----------------------------------------------------------------------------
// fcvm_checker
// Port-level checks on command and row beats, bound to the top level.
// ----------------------------------------------------------------------------
module fcvm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] row_index,
	input logic       last
);

	// A command beat starts a run; no second command is taken straight after.
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("command accepted while a run was starting");

	// Rows and commands never overlap.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("input ready while a row is offered");

	// The run stays busy until its last row beat.
	a_run_open: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> !in_ready)
		else $error("input ready before the last row");

	// Last marks exactly the third row, and no other index appears.
	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (row_index != 2'd3) && (last == (row_index == 2'd2)))
		else $error("row index and last disagree");

	a_row_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(row_index))
		else $error("stalled row beat changed");

endmodule

bind fly_camera_view_matrix fcvm_checker u_fcvm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (step_in.valid),
	.in_ready  (step_in.ready),
	.out_valid (row_out.valid),
	.out_ready (row_out.ready),
	.row_index (row_out.row_index),
	.last      (row_out.last)
);
